@@ rtl/tre_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types, rotor wiring tables, operation and register codes for the
// three-rotor letter cipher.
// ----------------------------------------------------------------------------
package tre_pkg;

   // Alphabet and position range
   localparam int unsigned LETTERS  = 26;
   localparam int unsigned POS_SPAN = LETTERS * LETTERS * LETTERS;

   // Reciprocal constants for splitting a position into base-26 digits:
   // floor(x / 26) = (x * RECIP26) >> SHIFT26 and floor(x / 676) likewise,
   // exact for every x below POS_SPAN.
   localparam int unsigned RECIP26   = 40330;
   localparam int unsigned SHIFT26   = 20;
   localparam int unsigned RECIP676  = 24819;
   localparam int unsigned SHIFT676  = 24;

   typedef logic [4:0]           letter_type;
   typedef letter_type [25:0]    letter_map_type;
   typedef logic [2:0]           choice_code_type;

   // Operation codes
   typedef logic [1:0] op_type;
   localparam op_type OP_ENCRYPT = 2'd0;
   localparam op_type OP_PLUG    = 2'd1;
   localparam op_type OP_LOAD    = 2'd2;

   // Configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type REG_FAST_CHOICE   = 2'd0;
   localparam csr_index_type REG_MIDDLE_CHOICE = 2'd1;
   localparam csr_index_type REG_SLOW_CHOICE   = 2'd2;

   localparam choice_code_type FAST_CHOICE_RESET   = 3'd0;
   localparam choice_code_type MIDDLE_CHOICE_RESET = 3'd1;
   localparam choice_code_type SLOW_CHOICE_RESET   = 3'd2;
   localparam choice_code_type CHOICE_MAX          = 3'd4;

   // Rotor offsets
   typedef struct packed {
      letter_type fast;
      letter_type middle;
      letter_type slow;
   } pos_type;

   // Wiring selected in each slot, already clamped to 0..4
   typedef struct packed {
      choice_code_type fast;
      choice_code_type middle;
      choice_code_type slow;
   } choice_type;

   // Position load precomputed at capture
   typedef struct packed {
      logic [14:0] value;   // start position mod POS_SPAN
      logic [9:0]  div26;   // value / 26
      letter_type  div676;  // value / 676
   } load_type;

   // Letter string (A first) to a table of letter codes
   function automatic letter_map_type text_to_map(input logic [26*8-1:0] text);
      letter_map_type m;
      for (int j = 0; j < 26; j++) begin
         m[j] = 5'(text[(25-j)*8 +: 8] - 8'd65);
      end
      return m;
   endfunction

   function automatic letter_map_type invert_map(input letter_map_type fwd);
      letter_map_type m;
      m = '0;
      for (int j = 0; j < 26; j++) begin
         m[fwd[j]] = 5'(j);
      end
      return m;
   endfunction

   function automatic letter_map_type identity_map();
      letter_map_type m;
      for (int j = 0; j < 26; j++) begin
         m[j] = 5'(j);
      end
      return m;
   endfunction

   localparam letter_map_type ROTOR_FWD [0:4] = '{
      text_to_map("EKMFLGDQVZNTOWYHXUSPAIBRCJ"),
      text_to_map("AJDKSIRUXBLHWTMCQGZNPYFVOE"),
      text_to_map("BDFHJLCPRTXVZNYEIWGAKMUSQO"),
      text_to_map("ESOVPZJAYQUIRHXLNFTGKDCMWB"),
      text_to_map("VZBRGITYUPSDNHLXAWMJQOFECK")
   };

   localparam letter_map_type ROTOR_INV [0:4] = '{
      invert_map(ROTOR_FWD[0]),
      invert_map(ROTOR_FWD[1]),
      invert_map(ROTOR_FWD[2]),
      invert_map(ROTOR_FWD[3]),
      invert_map(ROTOR_FWD[4])
   };

   localparam letter_map_type REFLECTOR = text_to_map("YRUHQSLDPXNGOKMIEBFZCWVJAT");

   // Notch letters R, F, W, K, A
   localparam letter_type NOTCH [0:4] = '{5'd17, 5'd5, 5'd22, 5'd10, 5'd0};

   localparam letter_map_type PLUG_RESET = identity_map();

   function automatic letter_type wrap26(input letter_type x);
      return (x >= 5'(LETTERS)) ? 5'(x - 5'(LETTERS)) : x;
   endfunction

   function automatic letter_type add_mod26(input letter_type a, input letter_type b);
      logic [5:0] s;
      s = 6'(a) + 6'(b);
      return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : 5'(s);
   endfunction

   // Both operands below 26; wraps modulo 32 to the right answer
   function automatic letter_type sub_mod26(input letter_type a, input letter_type b);
      return (a >= b) ? 5'(a - b) : 5'(a + 5'(LETTERS) - b);
   endfunction

   function automatic choice_code_type pick(input choice_code_type c);
      return (c > CHOICE_MAX) ? CHOICE_MAX : c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/tre_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tre_if
// Valid/ready channels of the cipher: request, response and register write.
// ----------------------------------------------------------------------------
interface tre_req_if;
   logic                valid;
   logic                ready;
   tre_pkg::op_type     operation;
   tre_pkg::letter_type letter_in;
   tre_pkg::letter_type plug_target;
   logic [14:0]         start_position;

   modport source (output valid, output operation, output letter_in,
                   output plug_target, output start_position, input ready);
   modport sink   (input valid, input operation, input letter_in,
                   input plug_target, input start_position, output ready);
endinterface

interface tre_rsp_if;
   logic                valid;
   logic                ready;
   tre_pkg::letter_type letter_out;
   tre_pkg::letter_type fast_offset;
   tre_pkg::letter_type middle_offset;
   tre_pkg::letter_type slow_offset;

   modport source (output valid, output letter_out, output fast_offset,
                   output middle_offset, output slow_offset, input ready);
   modport sink   (input valid, input letter_out, input fast_offset,
                   input middle_offset, input slow_offset, output ready);
endinterface

interface tre_csr_if;
   logic                     valid;
   logic                     ready;
   tre_pkg::csr_index_type   index;
   tre_pkg::choice_code_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/tre_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tre_stepper
// Rotor offset registers: odometer stepping with notch carries, and loading
// of a start position split into base-26 digits.
// ----------------------------------------------------------------------------
module tre_stepper (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                load_en,
   input  tre_pkg::load_type   load,
   input  tre_pkg::choice_type choice,
   output tre_pkg::pos_type    pos_in
);

   tre_pkg::pos_type    pos_ff;
   tre_pkg::pos_type    pos_step;
   tre_pkg::pos_type    pos_load;
   logic                carry_middle;
   logic                carry_slow;
   logic [14:0]         fast_prod;
   logic [9:0]          middle_prod;

   // Odometer step: the fast rotor always moves, carries at notch letters
   always_comb begin
      pos_step.fast = (pos_ff.fast == 5'(tre_pkg::LETTERS - 1)) ? '0 : 5'(pos_ff.fast + 5'd1);
      carry_middle  = (pos_step.fast == tre_pkg::NOTCH[choice.fast]);
      pos_step.middle = pos_ff.middle;
      if (carry_middle) begin
         pos_step.middle = (pos_ff.middle == 5'(tre_pkg::LETTERS - 1)) ?
                           '0 : 5'(pos_ff.middle + 5'd1);
      end
      carry_slow    = carry_middle && (pos_step.middle == tre_pkg::NOTCH[choice.middle]);
      pos_step.slow = pos_ff.slow;
      if (carry_slow) begin
         pos_step.slow = (pos_ff.slow == 5'(tre_pkg::LETTERS - 1)) ?
                         '0 : 5'(pos_ff.slow + 5'd1);
      end
   end

   // Digits of the loaded position from the precomputed quotients
   always_comb begin
      fast_prod       = 15'(load.div26) * 15'(tre_pkg::LETTERS);
      middle_prod     = 10'(load.div676) * 10'(tre_pkg::LETTERS);
      pos_load.fast   = 5'(load.value - fast_prod);
      pos_load.middle = 5'(load.div26 - middle_prod);
      pos_load.slow   = load.div676;
   end

   // Next offsets
   always_comb begin
      if (step_en) begin
         pos_in = pos_step;
      end else if (load_en) begin
         pos_in = pos_load;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tre_scrambler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tre_scrambler
// Letter path: plugboard, three rotors forward, reflector, three rotors back,
// plugboard.
// ----------------------------------------------------------------------------
module tre_scrambler (
   input  tre_pkg::letter_type     letter,
   input  tre_pkg::pos_type        pos,
   input  tre_pkg::choice_type     choice,
   input  tre_pkg::letter_map_type plug,
   output tre_pkg::letter_type     cipher
);

   tre_pkg::letter_type entry;
   tre_pkg::letter_type fwd_fast;
   tre_pkg::letter_type fwd_middle;
   tre_pkg::letter_type fwd_slow;
   tre_pkg::letter_type reflected;
   tre_pkg::letter_type back_slow;
   tre_pkg::letter_type back_middle;
   tre_pkg::letter_type back_fast;

   // Forward through plugboard and rotors: wiring at letter plus offset
   always_comb begin
      entry      = plug[tre_pkg::wrap26(letter)];
      fwd_fast   = tre_pkg::ROTOR_FWD[choice.fast][tre_pkg::add_mod26(entry, pos.fast)];
      fwd_middle = tre_pkg::ROTOR_FWD[choice.middle][tre_pkg::add_mod26(fwd_fast, pos.middle)];
      fwd_slow   = tre_pkg::ROTOR_FWD[choice.slow][tre_pkg::add_mod26(fwd_middle, pos.slow)];
      reflected  = tre_pkg::REFLECTOR[fwd_slow];
   end

   // Back through inverse wirings, minus offset, then plugboard
   always_comb begin
      back_slow   = tre_pkg::sub_mod26(tre_pkg::ROTOR_INV[choice.slow][reflected], pos.slow);
      back_middle = tre_pkg::sub_mod26(tre_pkg::ROTOR_INV[choice.middle][back_slow],
                                       pos.middle);
      back_fast   = tre_pkg::sub_mod26(tre_pkg::ROTOR_INV[choice.fast][back_middle],
                                       pos.fast);
      cipher      = plug[back_fast];
   end

endmodule
`default_nettype wire

@@ rtl/three_rotor_enigma_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_rotor_enigma_cipher
// Three-rotor letter cipher with plugboard, reflector B and five wirings.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock while the response side
// is not stalled and returns one response transaction per request, in order:
// a request is captured into an input register (where a start position is
// reduced and split by reciprocal multiplies), and once the response register
// can take it, rotor stepping, the full letter path and any state update are
// done in one pass into the response register. Rotor state advances as each
// item leaves the input register, so consecutive encrypt items see each
// other's stepping. Register writes are always ready and take effect at once;
// write them only while no request is in flight.
module three_rotor_enigma_cipher (
   input  logic      clock,
   input  logic      reset,
   tre_req_if.sink   req_ch,
   tre_rsp_if.source rsp_ch,
   tre_csr_if.sink   csr_ch
);

   // Configuration registers
   tre_pkg::choice_code_type fast_choice_ff;
   tre_pkg::choice_code_type middle_choice_ff;
   tre_pkg::choice_code_type slow_choice_ff;
   tre_pkg::choice_type      choice;

   // Input register
   logic                     in_valid_ff;
   logic                     in_valid_in;
   tre_pkg::op_type          in_op_ff;
   tre_pkg::letter_type      in_letter_ff;
   tre_pkg::letter_type      in_target_ff;
   tre_pkg::load_type        in_load_ff;
   tre_pkg::load_type        load_in;

   // Response register
   logic                     out_valid_ff;
   logic                     out_valid_in;
   tre_pkg::letter_type      out_letter_ff;
   tre_pkg::pos_type         out_pos_ff;

   // Plugboard
   tre_pkg::letter_map_type  plug_ff;

   logic                     req_take;
   logic                     fire;
   logic [14:0]              pos_mod;
   logic [30:0]              div26_prod;
   logic [29:0]              div676_prod;
   tre_pkg::pos_type         pos_in;
   tre_pkg::letter_type      cipher;

   // Handshake
   assign fire         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   // Start position: reduce and divide by 26 and 676 at capture
   always_comb begin
      pos_mod = (req_ch.start_position >= 15'(tre_pkg::POS_SPAN)) ?
                15'(req_ch.start_position - 15'(tre_pkg::POS_SPAN)) :
                req_ch.start_position;
      div26_prod     = 31'(pos_mod) * 31'(tre_pkg::RECIP26);
      div676_prod    = 30'(pos_mod) * 30'(tre_pkg::RECIP676);
      load_in.value  = pos_mod;
      load_in.div26  = div26_prod[tre_pkg::SHIFT26 +: 10];
      load_in.div676 = div676_prod[tre_pkg::SHIFT676 +: 5];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff     <= req_ch.operation;
         in_letter_ff <= req_ch.letter_in;
         in_target_ff <= req_ch.plug_target;
         in_load_ff   <= load_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_choice_ff   <= tre_pkg::FAST_CHOICE_RESET;
         middle_choice_ff <= tre_pkg::MIDDLE_CHOICE_RESET;
         slow_choice_ff   <= tre_pkg::SLOW_CHOICE_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            tre_pkg::REG_FAST_CHOICE:   fast_choice_ff   <= csr_ch.data;
            tre_pkg::REG_MIDDLE_CHOICE: middle_choice_ff <= csr_ch.data;
            tre_pkg::REG_SLOW_CHOICE:   slow_choice_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign choice.fast   = tre_pkg::pick(fast_choice_ff);
   assign choice.middle = tre_pkg::pick(middle_choice_ff);
   assign choice.slow   = tre_pkg::pick(slow_choice_ff);

   // Plugboard entries; writes beyond Z are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         plug_ff <= tre_pkg::PLUG_RESET;
      end else if (fire && (in_op_ff == tre_pkg::OP_PLUG) &&
                   (in_letter_ff < 5'(tre_pkg::LETTERS))) begin
         plug_ff[in_letter_ff] <= tre_pkg::wrap26(in_target_ff);
      end
   end

   tre_stepper u_stepper (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire && (in_op_ff == tre_pkg::OP_ENCRYPT)),
      .load_en (fire && (in_op_ff == tre_pkg::OP_LOAD)),
      .load    (in_load_ff),
      .choice  (choice),
      .pos_in  (pos_in)
   );

   tre_scrambler u_scrambler (
      .letter (in_letter_ff),
      .pos    (pos_in),
      .choice (choice),
      .plug   (plug_ff),
      .cipher (cipher)
   );

   // Response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         out_letter_ff <= (in_op_ff == tre_pkg::OP_ENCRYPT) ? cipher : '0;
         out_pos_ff    <= pos_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.letter_out    = out_letter_ff;
   assign rsp_ch.fast_offset   = out_pos_ff.fast;
   assign rsp_ch.middle_offset = out_pos_ff.middle;
   assign rsp_ch.slow_offset   = out_pos_ff.slow;

endmodule
`default_nettype wire
